>>> sv/tccu_pkg.sv
package tccu_pkg;

  // field widths fixed by the cell command format
  localparam int COL_W   = 8;
  localparam int ROW_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int CMD_W   = 2;
  localparam int QUEUE_D = 4;

  // cell commands
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD    = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_LF     = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TILDE  = 8'd126;
  localparam logic [CHAR_W-1:0] CHAR_DEL    = 8'd127;
  localparam logic [CHAR_W-1:0] CURSOR_GLYPH = 8'd95;

  // one cell command word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  text_row;
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } result_t;

  // control broadcast along the line-end cell row
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [COL_W-1:0] wr_val;
    logic [ROW_W-1:0] rd_row;
  } cell_ctl_t;

endpackage

>>> sv/tccu_char_if.sv
interface tccu_char_if import tccu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

>>> sv/tccu_result_if.sv
interface tccu_result_if import tccu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  text_row;
  logic [CHAR_W-1:0] glyph;
  logic              last;

  modport source (output valid, output command, output column, output text_row,
                  output glyph, output last, input ready);
  modport sink   (input valid, input command, input column, input text_row,
                  input glyph, input last, output ready);
endinterface

>>> sv/tccu_cell.sv
module tccu_cell import tccu_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [COL_W-1:0] up_w,
  output logic [COL_W-1:0] w_out,
  input  logic [COL_W-1:0] rd_in,
  output logic [COL_W-1:0] rd_out
);

  logic [COL_W-1:0] line_end;
  logic [COL_W-1:0] line_end_next;

  // write first, then take the neighbor's written value on a scroll
  assign w_out         = (ctl.wr_en && ctl.wr_row == ROW_W'(INDEX)) ? ctl.wr_val : line_end;
  assign line_end_next = ctl.shift ? up_w : w_out;

  // read chain: the selected cell puts its value on the bus
  assign rd_out = rd_in | ((ctl.rd_row == ROW_W'(INDEX)) ? line_end : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_end <= '0;
    end else begin
      line_end <= line_end_next;
    end
  end

endmodule

>>> sv/text_console_cursor_engine_unit.sv
// Text console cursor engine. Each character word on char_in produces one to four
// cell command words on res_out, one word per cycle while res_out.ready is high, the
// final one flagged by last: one for an unsupported code, two for line feed or
// carriage return, three for printable text, for delete and for a line feed or
// carriage return on the bottom row that scrolls, four when a printable character
// wraps on the bottom row and scrolls. All results of a character are worked out in
// the cycle it is accepted and queued in a four-word output queue; the next character
// is taken in the same cycle the last queued word leaves. The per-row line ends live
// in a row of ROWS cells that shift up by one on a scroll.
module text_console_cursor_engine_unit import tccu_pkg::*; #(
  parameter int COLUMNS = 160,
  parameter int ROWS    = 50
) (
  input logic          clk,
  input logic          rst,
  tccu_char_if.sink    char_in,
  tccu_result_if.source res_out
);

  localparam int QCNT_W = $clog2(QUEUE_D + 1);

  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col_next;
  logic [ROW_W-1:0]  cursor_row_next;
  result_t           queue [QUEUE_D];
  result_t           queue_next [QUEUE_D];
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  result_t           new_words [QUEUE_D];
  logic [QCNT_W-1:0] new_count;
  cell_ctl_t         ctl;
  logic [COL_W-1:0]  w_chain  [ROWS+1];
  logic [COL_W-1:0]  rd_chain [ROWS+1];
  logic              accept;
  logic              pop;

  logic [CHAR_W-1:0] c;
  logic              is_print, is_nl, is_del, is_bad;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic              at_bottom;
  logic [ROW_W-1:0]  bottom_row;

  assign pop    = res_out.valid && res_out.ready;
  assign char_in.ready = (count == '0) || (count == QCNT_W'(1) && pop);
  assign accept = char_in.valid && char_in.ready;

  // character class decode
  assign c          = char_in.char_code;
  assign is_print   = (c >= CHAR_SPACE) && (c <= CHAR_TILDE);
  assign is_nl      = (c == CHAR_LF) || (c == CHAR_CR);
  assign is_del     = (c == CHAR_DEL);
  assign is_bad     = !(is_print || is_nl || is_del);
  assign col_inc    = {1'b0, cursor_col} + (COL_W+1)'(1);
  assign wrap       = col_inc >= (COL_W+1)'(COLUMNS);
  assign bottom_row = ROW_W'(ROWS - 1);
  assign at_bottom  = (cursor_row == bottom_row);

  // build the result words and the state update for the offered character
  always_comb begin
    result_t erase0, scroll_w;
    erase0   = '{command: CMD_ERASE, column: cursor_col, text_row: cursor_row,
                 glyph: '0, last: 1'b0};
    scroll_w = '{command: CMD_SCROLL, column: '0, text_row: bottom_row,
                 glyph: '0, last: 1'b0};
    for (int i = 0; i < QUEUE_D; i++) new_words[i] = '0;
    new_count       = QCNT_W'(1);
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    ctl.shift  = 1'b0;
    ctl.wr_en  = 1'b0;
    ctl.wr_row = cursor_row;
    ctl.wr_val = '0;
    ctl.rd_row = cursor_row - ROW_W'(1);

    priority if (is_bad) begin
      new_words[0] = '{command: CMD_BAD, column: cursor_col, text_row: cursor_row,
                       glyph: '0, last: 1'b1};
      new_count = QCNT_W'(1);
    end else if (is_print) begin
      new_words[0] = erase0;
      new_words[1] = '{command: CMD_DRAW, column: cursor_col, text_row: cursor_row,
                       glyph: c, last: 1'b0};
      ctl.wr_en  = 1'b1;
      ctl.wr_val = cursor_col;
      if (wrap) begin
        cursor_col_next = '0;
        if (at_bottom) begin
          ctl.shift    = 1'b1;
          new_words[2] = scroll_w;
          new_words[3] = '{command: CMD_DRAW, column: '0, text_row: cursor_row,
                           glyph: CURSOR_GLYPH, last: 1'b1};
          new_count    = QCNT_W'(4);
        end else begin
          cursor_row_next = cursor_row + ROW_W'(1);
          new_words[2] = '{command: CMD_DRAW, column: '0, text_row: cursor_row_next,
                           glyph: CURSOR_GLYPH, last: 1'b1};
          new_count    = QCNT_W'(3);
        end
      end else begin
        cursor_col_next = col_inc[COL_W-1:0];
        new_words[2] = '{command: CMD_DRAW, column: cursor_col_next,
                         text_row: cursor_row, glyph: CURSOR_GLYPH, last: 1'b1};
        new_count    = QCNT_W'(3);
      end
    end else if (is_nl) begin
      new_words[0]    = erase0;
      cursor_col_next = '0;
      if (at_bottom) begin
        ctl.shift    = 1'b1;
        new_words[1] = scroll_w;
        new_words[2] = '{command: CMD_DRAW, column: '0, text_row: cursor_row,
                         glyph: CURSOR_GLYPH, last: 1'b1};
      end else begin
        cursor_row_next = cursor_row + ROW_W'(1);
        new_words[1] = '{command: CMD_DRAW, column: '0, text_row: cursor_row_next,
                         glyph: CURSOR_GLYPH, last: 1'b1};
      end
      new_count = QCNT_W'(at_bottom ? 3 : 2);
    end else begin
      // delete: step back, across the line start when at column zero below the top row
      new_words[0] = erase0;
      if (cursor_col != '0) begin
        cursor_col_next = cursor_col - COL_W'(1);
        ctl.wr_en  = 1'b1;
        ctl.wr_val = cursor_col_next;
      end else if (cursor_row != '0) begin
        ctl.wr_en       = 1'b1;
        ctl.wr_val      = '0;
        cursor_row_next = cursor_row - ROW_W'(1);
        cursor_col_next = rd_chain[ROWS];
      end
      new_words[1] = '{command: CMD_ERASE, column: cursor_col_next,
                       text_row: cursor_row_next, glyph: '0, last: 1'b0};
      new_words[2] = '{command: CMD_DRAW, column: cursor_col_next,
                       text_row: cursor_row_next, glyph: CURSOR_GLYPH, last: 1'b1};
      new_count    = QCNT_W'(3);
    end

    // cells change only for an accepted character
    if (!accept) begin
      ctl.shift = 1'b0;
      ctl.wr_en = 1'b0;
    end
  end

  // line-end cell row
  assign w_chain[ROWS] = '0;
  assign rd_chain[0]   = '0;

  for (genvar g = 0; g < ROWS; g++) begin : g_cell
    tccu_cell #(.INDEX(g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .up_w   (w_chain[g+1]),
      .w_out  (w_chain[g]),
      .rd_in  (rd_chain[g]),
      .rd_out (rd_chain[g+1])
    );
  end

  // output queue: load on accept, shift toward the head on pop
  always_comb begin
    for (int i = 0; i < QUEUE_D; i++) queue_next[i] = queue[i];
    count_next = count;
    if (accept) begin
      for (int i = 0; i < QUEUE_D; i++) queue_next[i] = new_words[i];
      count_next = new_count;
    end else if (pop) begin
      for (int i = 0; i < QUEUE_D - 1; i++) queue_next[i] = queue[i+1];
      queue_next[QUEUE_D-1] = '0;
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_D; i++) queue[i] <= queue_next[i];
  end

  assign res_out.valid    = (count != '0);
  assign res_out.command  = queue[0].command;
  assign res_out.column   = queue[0].column;
  assign res_out.text_row = queue[0].text_row;
  assign res_out.glyph    = queue[0].glyph;
  assign res_out.last     = queue[0].last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_D))
    else $error("output queue count out of range");

  a_last_is_tail: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (res_out.last == (count == QCNT_W'(1))))
    else $error("last flag not on the final queued word");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (cursor_col < COL_W'(COLUMNS)) && (cursor_row < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!accept && !pop) |=> $stable(cursor_col) && $stable(cursor_row) && $stable(count))
    else $error("state moved without a handshake");

endmodule
